// File: sv/ptw_pkg.sv
// shared constants, types and helpers for the four-level page table walker
// no dependencies; used by ptw_walk, ptw_out_buf and the top level
package ptw_pkg;

  localparam int PHYS_ADDR_BITS = 56;
  localparam int VA_BITS        = 48;
  localparam int BASE_BITS      = 52;
  localparam int ENTRY_BITS     = 64;
  localparam int OUT_ADDR_BITS  = 56;
  localparam int IDX_BITS       = 9;

  // entry bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  localparam logic [OUT_ADDR_BITS-1:0] ADDR_MASK =
    OUT_ADDR_BITS'(({(OUT_ADDR_BITS+1){1'b0}} | 1) << PHYS_ADDR_BITS) - OUT_ADDR_BITS'(1);
  localparam logic [OUT_ADDR_BITS-1:0] FRAME_MASK =
    ADDR_MASK & ~OUT_ADDR_BITS'(12'hFFF);
  localparam logic [OUT_ADDR_BITS-1:0] GIB_MASK  = ~OUT_ADDR_BITS'(30'h3FFF_FFFF);
  localparam logic [OUT_ADDR_BITS-1:0] MIB2_MASK = ~OUT_ADDR_BITS'(21'h1F_FFFF);

  typedef enum logic [0:0] {
    ACT_REQUEST = 1'b0,
    ACT_ENTRY   = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    LVL_TOP  = 2'd0,
    LVL_1GIB = 2'd1,
    LVL_2MIB = 2'd2,
    LVL_LEAF = 2'd3
  } level_t;

  typedef struct packed {
    logic               busy;
    level_t             level;
    logic [VA_BITS-1:0] va;
  } ptw_state_t;

  typedef struct packed {
    logic                     emit;
    kind_t                    kind;
    logic [OUT_ADDR_BITS-1:0] read_address;
    logic [OUT_ADDR_BITS-1:0] phys_addr;
    logic                     found;
  } ptw_result_t;

  // table index of the virtual address for a given level
  function automatic logic [IDX_BITS-1:0] level_index(input logic [VA_BITS-1:0] va,
                                                      input level_t lv);
    logic [IDX_BITS-1:0] idx;
    unique case (lv)
      LVL_TOP:  idx = va[47:39];
      LVL_1GIB: idx = va[38:30];
      LVL_2MIB: idx = va[29:21];
      LVL_LEAF: idx = va[20:12];
      default:  idx = '0;
    endcase
    return idx;
  endfunction

endpackage

// File: sv/four_level_page_table_walker_top.sv
// top level of the four-level page table walker
// depends on ptw_pkg, ptw_walk and ptw_out_buf
//
// usage:
//   in channel: in_action = 0 starts a translation of in_virt_addr at
//   the top-level table in_directory_base; in_action = 1 returns the 64-bit
//   entry word in in_entry_value for the last read requested
//   out channel: out_kind = 0 is a read request for the 8-byte entry at
//   out_read_address; out_kind = 1 is a finished translation with
//   out_found and out_phys_addr (zero on a fault)
//   each accepted word gives at most one result word; an entry with no walk
//   running is dropped, a new request abandons any running walk
// path: a result word passes the input register, then the result register,
//   before out_valid rises; throughput: one word per cycle while out_ready
//   stays high, set by the single decode step between the two registers
// reset: rst_n low clears the walk state to idle and empties both registers
// stall: while out_ready is low the result register holds its word; the
//   input register keeps accepting until it also holds a word awaiting room
module four_level_page_table_walker_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic [ptw_pkg::VA_BITS-1:0]          in_virt_addr,
  input  logic [ptw_pkg::BASE_BITS-1:0]        in_directory_base,
  input  logic [ptw_pkg::ENTRY_BITS-1:0]       in_entry_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_kind,
  output logic [ptw_pkg::OUT_ADDR_BITS-1:0]    out_read_address,
  output logic [ptw_pkg::OUT_ADDR_BITS-1:0]    out_phys_addr,
  output logic                                 out_found
);

  // input register
  logic                              s1_valid_r;
  logic                              s1_action_r;
  logic [ptw_pkg::VA_BITS-1:0]       s1_va_r;
  logic [ptw_pkg::BASE_BITS-1:0]     s1_base_r;
  logic [ptw_pkg::ENTRY_BITS-1:0]    s1_entry_r;

  // walk state, updated as each word leaves the input register
  ptw_pkg::ptw_state_t  state_r;
  ptw_pkg::ptw_state_t  state_nxt;

  ptw_pkg::ptw_result_t res;
  ptw_pkg::ptw_result_t held;
  logic                 out_free;
  logic                 s1_adv;
  logic                 in_fire;

  // a word with no result leaves without waiting for the output side
  assign s1_adv   = s1_valid_r && (!res.emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_action;
      s1_va_r     <= in_virt_addr;
      s1_base_r   <= in_directory_base;
      s1_entry_r  <= in_entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  ptw_walk u_walk (
    .action          (s1_action_r),
    .virt_addr       (s1_va_r),
    .directory_base  (s1_base_r),
    .entry_value     (s1_entry_r),
    .st              (state_r),
    .st_nxt          (state_nxt),
    .res             (res)
  );

  ptw_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_valid_r && res.emit),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign out_kind         = held.kind;
  assign out_read_address = held.read_address;
  assign out_phys_addr    = held.phys_addr;
  assign out_found        = held.found;

  // idle walk always rests at the top level
  a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.busy |-> state_r.level == ptw_pkg::LVL_TOP)
    else $error("walk idle with nonzero level");

  // read requests carry no translation
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ptw_pkg::KIND_READ |-> !out_found && out_phys_addr == '0)
    else $error("read request with translation fields set");

  // a fault reports a zero address
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ptw_pkg::KIND_DONE && !out_found |-> out_phys_addr == '0)
    else $error("fault with nonzero physical address");

  // an empty result register never blocks the input side
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

// File: sv/ptw_walk.sv
// one walk step: decodes a request or returned entry against the walk state
// depends on ptw_pkg
module ptw_walk (
  input  logic                                 action,
  input  logic [ptw_pkg::VA_BITS-1:0]          virt_addr,
  input  logic [ptw_pkg::BASE_BITS-1:0]        directory_base,
  input  logic [ptw_pkg::ENTRY_BITS-1:0]       entry_value,
  input  ptw_pkg::ptw_state_t                  st,
  output ptw_pkg::ptw_state_t                  st_nxt,
  output ptw_pkg::ptw_result_t                 res
);

  logic [ptw_pkg::OUT_ADDR_BITS-1:0] frame;
  logic [ptw_pkg::OUT_ADDR_BITS-1:0] base_addr;
  logic [ptw_pkg::OUT_ADDR_BITS-1:0] top_off;
  logic [ptw_pkg::OUT_ADDR_BITS-1:0] next_off;
  ptw_pkg::level_t                   lv_next;

  assign frame     = entry_value[ptw_pkg::OUT_ADDR_BITS-1:0] & ptw_pkg::FRAME_MASK;
  assign base_addr = ptw_pkg::OUT_ADDR_BITS'({directory_base[ptw_pkg::BASE_BITS-1:4], 4'b0000});
  assign top_off   = ptw_pkg::OUT_ADDR_BITS'({ptw_pkg::level_index(virt_addr,
                                              ptw_pkg::LVL_TOP), 3'b000});
  assign lv_next   = ptw_pkg::level_t'(st.level + 2'd1);
  assign next_off  = ptw_pkg::OUT_ADDR_BITS'({ptw_pkg::level_index(st.va, lv_next), 3'b000});

  always_comb begin
    st_nxt = st;
    res    = '0;
    priority if (action == ptw_pkg::ACT_REQUEST) begin
      st_nxt.busy      = 1'b1;
      st_nxt.level     = ptw_pkg::LVL_TOP;
      st_nxt.va        = virt_addr;
      res.emit         = 1'b1;
      res.kind         = ptw_pkg::KIND_READ;
      res.read_address = (base_addr + top_off) & ptw_pkg::ADDR_MASK;
    end else if (!st.busy) begin
      // stray entry with no walk running: dropped
      res.emit = 1'b0;
    end else if (!entry_value[ptw_pkg::BIT_PRESENT]) begin
      st_nxt.busy  = 1'b0;
      st_nxt.level = ptw_pkg::LVL_TOP;
      res.emit     = 1'b1;
      res.kind     = ptw_pkg::KIND_DONE;
    end else if (st.level == ptw_pkg::LVL_1GIB && entry_value[ptw_pkg::BIT_LARGE]) begin
      st_nxt.busy   = 1'b0;
      st_nxt.level  = ptw_pkg::LVL_TOP;
      res.emit      = 1'b1;
      res.kind      = ptw_pkg::KIND_DONE;
      res.found     = 1'b1;
      res.phys_addr = ((frame & ptw_pkg::GIB_MASK)
                      + ptw_pkg::OUT_ADDR_BITS'(st.va[29:0])) & ptw_pkg::ADDR_MASK;
    end else if (st.level == ptw_pkg::LVL_2MIB && entry_value[ptw_pkg::BIT_LARGE]) begin
      st_nxt.busy   = 1'b0;
      st_nxt.level  = ptw_pkg::LVL_TOP;
      res.emit      = 1'b1;
      res.kind      = ptw_pkg::KIND_DONE;
      res.found     = 1'b1;
      res.phys_addr = ((frame & ptw_pkg::MIB2_MASK)
                      + ptw_pkg::OUT_ADDR_BITS'(st.va[20:0])) & ptw_pkg::ADDR_MASK;
    end else if (st.level == ptw_pkg::LVL_LEAF) begin
      st_nxt.busy   = 1'b0;
      st_nxt.level  = ptw_pkg::LVL_TOP;
      res.emit      = 1'b1;
      res.kind      = ptw_pkg::KIND_DONE;
      res.found     = 1'b1;
      res.phys_addr = (frame + ptw_pkg::OUT_ADDR_BITS'(st.va[11:0]))
                      & ptw_pkg::ADDR_MASK;
    end else begin
      st_nxt.level     = lv_next;
      res.emit         = 1'b1;
      res.kind         = ptw_pkg::KIND_READ;
      res.read_address = (frame + next_off) & ptw_pkg::ADDR_MASK;
    end
  end

endmodule

// File: sv/ptw_out_buf.sv
// output register for result words with valid/ready toward the receiver
// depends on ptw_pkg
module ptw_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  ptw_pkg::ptw_result_t res,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ptw_pkg::ptw_result_t held
);

  logic                 valid_r;
  ptw_pkg::ptw_result_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign held      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= res;
    end
  end

endmodule

// File: test/tb_top.sv
// self-checking bench for four_level_page_table_walker_top: walks, faults and large pages
// drives both channels with random gaps and checks every result word against its walk model
// depends on ptw_pkg for widths, entry bit positions and the action, kind and level enums
module tb_top;

  // one word for the input channel, plus how it is to be driven
  typedef struct {
    ptw_pkg::action_t                action;
    logic [ptw_pkg::VA_BITS-1:0]     va;
    logic [ptw_pkg::BASE_BITS-1:0]   base;
    logic [ptw_pkg::ENTRY_BITS-1:0]  entry;
    int                              gap;   // idle cycles before this word is offered
    bit                              hold;  // offer only once every result has come back
  } walk_word_t;

  // one word expected on the result channel
  typedef struct {
    ptw_pkg::kind_t                    kind;
    logic [ptw_pkg::OUT_ADDR_BITS-1:0] read_address;
    logic [ptw_pkg::OUT_ADDR_BITS-1:0] phys_addr;
    logic                              found;
  } result_word_t;

  // address masks, kept in 64 bits for the walk arithmetic
  localparam logic [63:0] ADDR_KEEP  = (64'd1 << ptw_pkg::PHYS_ADDR_BITS) - 64'd1;
  localparam logic [63:0] FRAME_KEEP = ADDR_KEEP & ~64'hFFF;
  localparam logic [63:0] GIB_OFS    = (64'd1 << 30) - 64'd1;
  localparam logic [63:0] MIB2_OFS   = (64'd1 << 21) - 64'd1;
  localparam logic [63:0] PAGE_OFS   = 64'hFFF;
  localparam int          STALL_LIMIT = 3000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              in_action = 1'b0;
  logic [ptw_pkg::VA_BITS-1:0]       in_virt_addr = '0;
  logic [ptw_pkg::BASE_BITS-1:0]     in_directory_base = '0;
  logic [ptw_pkg::ENTRY_BITS-1:0]    in_entry_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              out_kind;
  logic [ptw_pkg::OUT_ADDR_BITS-1:0] out_read_address;
  logic [ptw_pkg::OUT_ADDR_BITS-1:0] out_phys_addr;
  logic                              out_found;

  four_level_page_table_walker_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_virt_addr         (in_virt_addr),
    .in_directory_base    (in_directory_base),
    .in_entry_value       (in_entry_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_read_address     (out_read_address),
    .out_phys_addr        (out_phys_addr),
    .out_found            (out_found)
  );

  always #5 clk = ~clk;

  walk_word_t   pending_words[$];
  result_word_t expected_words[$];
  walk_word_t   cur_word;

  // walk model state: busy flag, level of the entry awaited, latched address
  bit                          w_busy = 1'b0;
  ptw_pkg::level_t             w_level = ptw_pkg::LVL_TOP;
  logic [ptw_pkg::VA_BITS-1:0] w_va = '0;

  int  mismatches = 0;
  int  words_queued = 0;
  int  reads_seen = 0;
  int  found_seen = 0;
  int  faults_seen = 0;
  int  cyc = 0;
  int  idle_wait = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  bit  calm_stretch = 1'b0;
  bit  drained = 1'b1;

  // byte offset of the 8-byte entry that the address selects at a level
  function automatic logic [63:0] table_slot(input logic [ptw_pkg::VA_BITS-1:0] va,
                                             input ptw_pkg::level_t lv);
    logic [ptw_pkg::VA_BITS-1:0] sh;
    sh = va >> (39 - 9 * int'(lv));
    return {55'd0, sh[8:0]} << 3;
  endfunction

  // mostly short gaps, a few long ones, none during a calm stretch
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ptw_pkg::VA_BITS-1:0] rand_va();
    int r;
    logic [63:0] v;
    r = $urandom_range(0, 99);
    v = rand64();
    if (r < 5) return '0;
    if (r < 10) return '1;
    return v[ptw_pkg::VA_BITS-1:0];
  endfunction

  function automatic logic [ptw_pkg::BASE_BITS-1:0] rand_base();
    int r;
    logic [63:0] v;
    r = $urandom_range(0, 99);
    v = rand64();
    if (r < 5) return '0;
    if (r < 10) return '1;
    return v[ptw_pkg::BASE_BITS-1:0];
  endfunction

  task automatic push_word(input ptw_pkg::action_t a, input logic [ptw_pkg::VA_BITS-1:0] va,
                           input logic [ptw_pkg::BASE_BITS-1:0] base,
                           input logic [ptw_pkg::ENTRY_BITS-1:0] entry, input bit hold);
    walk_word_t w;
    w.action = a;
    w.va     = va;
    w.base   = base;
    w.entry  = entry;
    w.gap    = pick_gap(calm_stretch);
    // every few hundred words the sender also waits for the result side to drain
    w.hold   = hold || (words_queued % 400 == 399);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // a request followed by entries shaped so the walk ends where it should;
  // a cut walk stops early and the next request abandons it
  task automatic queue_walk(input bit cut);
    int lv;
    int stop_at;
    int r;
    bit ended;
    logic [63:0] e;
    push_word(ptw_pkg::ACT_REQUEST, rand_va(), rand_base(), rand64(), 1'b0);
    stop_at = cut ? $urandom_range(0, 3) : 4;
    ended = 1'b0;
    for (lv = 0; lv < stop_at && !ended; lv++) begin
      e = rand64();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        e[ptw_pkg::BIT_PRESENT] = 1'b0;
        ended = 1'b1;
      end else begin
        e[ptw_pkg::BIT_PRESENT] = 1'b1;
      end
      if (!ended && (lv == 1 || lv == 2)) begin
        e[ptw_pkg::BIT_LARGE] = (r < 40);
        ended = (r < 40);
      end
      if (lv == 3) ended = 1'b1;
      push_word(ptw_pkg::ACT_ENTRY, rand_va(), rand_base(), e, 1'b0);
    end
  endtask

  // walk model: one accepted word in, zero or one expected result out
  task automatic walk_step(input walk_word_t w);
    result_word_t r;
    logic [63:0] frame;
    logic [63:0] sum;
    logic [63:0] va64;
    bit          finish_walk;
    r.kind = ptw_pkg::KIND_READ;
    r.read_address = '0;
    r.phys_addr = '0;
    r.found = 1'b0;
    if (w.action == ptw_pkg::ACT_REQUEST) begin
      // a request always restarts, even over a running walk
      w_va = w.va;
      w_level = ptw_pkg::LVL_TOP;
      w_busy = 1'b1;
      sum = ({12'd0, w.base} & ~64'hF) + table_slot(w.va, ptw_pkg::LVL_TOP);
      sum = sum & ADDR_KEEP;
      r.read_address = sum[ptw_pkg::OUT_ADDR_BITS-1:0];
      expected_words.push_back(r);
    end else if (w_busy) begin
      frame = w.entry & FRAME_KEEP;
      va64 = {16'd0, w_va};
      finish_walk = 1'b1;
      r.kind = ptw_pkg::KIND_DONE;
      if (!w.entry[ptw_pkg::BIT_PRESENT]) begin
        sum = '0;
      end else if (w_level == ptw_pkg::LVL_1GIB && w.entry[ptw_pkg::BIT_LARGE]) begin
        sum = (frame & ~GIB_OFS) + (va64 & GIB_OFS);
        r.found = 1'b1;
      end else if (w_level == ptw_pkg::LVL_2MIB && w.entry[ptw_pkg::BIT_LARGE]) begin
        sum = (frame & ~MIB2_OFS) + (va64 & MIB2_OFS);
        r.found = 1'b1;
      end else if (w_level == ptw_pkg::LVL_LEAF) begin
        // leaf success rests on the present bit only, a zero frame is fine
        sum = frame + (va64 & PAGE_OFS);
        r.found = 1'b1;
      end else begin
        finish_walk = 1'b0;
        r.kind = ptw_pkg::KIND_READ;
        w_level = ptw_pkg::level_t'(w_level + 2'd1);
        sum = frame + table_slot(w_va, w_level);
      end
      sum = sum & ADDR_KEEP;
      if (finish_walk) begin
        w_busy = 1'b0;
        w_level = ptw_pkg::LVL_TOP;
        r.phys_addr = sum[ptw_pkg::OUT_ADDR_BITS-1:0];
      end else begin
        r.read_address = sum[ptw_pkg::OUT_ADDR_BITS-1:0];
      end
      expected_words.push_back(r);
    end
    // an entry with no walk running is dropped and expects nothing
  endtask

  // sampled away from the rising edge so the hold-off sees a settled queue
  always @(negedge clk) begin
    drained <= (expected_words.size() == 0);
  end

  // driver: offers the oldest pending word, keeps it steady until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_wait <= 0;
    end else begin
      if (in_valid && in_ready) walk_step(cur_word);
      if (!in_valid || in_ready) begin
        if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_words[0].hold && (in_valid || !drained)) begin
          // pause until every result so far has been taken
          in_valid <= 1'b0;
        end else if (idle_wait < pending_words[0].gap) begin
          in_valid  <= 1'b0;
          idle_wait <= idle_wait + 1;
        end else begin
          cur_word = pending_words.pop_front();
          in_action          <= cur_word.action;
          in_virt_addr       <= cur_word.va;
          in_directory_base  <= cur_word.base;
          in_entry_value     <= cur_word.entry;
          in_valid           <= 1'b1;
          idle_wait          <= 0;
        end
      end
    end
  end

  // monitor: checks each taken result word, then decides the next ready
  always @(posedge clk) begin
    result_word_t ew;
    int n;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      cyc <= cyc + 1;
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: kind %0d read %h phys %h found %0d",
                 out_kind, out_read_address, out_phys_addr, out_found);
          mismatches++;
        end else begin
          ew = expected_words.pop_front();
          if (out_kind !== ew.kind) begin
            $error("kind: expected %0d, got %0d", ew.kind, out_kind);
            mismatches++;
          end
          if (out_read_address !== ew.read_address) begin
            $error("read_address: expected %h, got %h", ew.read_address, out_read_address);
            mismatches++;
          end
          if (out_phys_addr !== ew.phys_addr) begin
            $error("phys_addr: expected %h, got %h",
                   ew.phys_addr, out_phys_addr);
            mismatches++;
          end
          if (out_found !== ew.found) begin
            $error("found: expected %0d, got %0d", ew.found, out_found);
            mismatches++;
          end
          if (ew.kind == ptw_pkg::KIND_READ) reads_seen++;
          else if (ew.found) found_seen++;
          else faults_seen++;
        end
      end
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        // every so often a long stretch with the receiver always ready
        n = pick_gap((cyc / 1500) % 5 == 0);
        if (n == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready  <= 1'b0;
          stall_left <= n - 1;
        end
      end
    end
  end

  // watchdog: too long with nothing taken on either channel ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    int next_reroll;
    // directed part
    // entry with no walk running is dropped
    push_word(ptw_pkg::ACT_ENTRY, '1, '1, '1, 1'b0);
    // all-zero address and base, then a full walk of present entries with zero
    // frames, so the leaf gives found with only the page offset
    push_word(ptw_pkg::ACT_REQUEST, '0, '0, '0, 1'b0);
    repeat (4) push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'h1, 1'b0);
    // all-ones request; all-ones top entry keeps walking despite the large bit,
    // the next one maps a 1 GiB page
    push_word(ptw_pkg::ACT_REQUEST, '1, '1, '1, 1'b1);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, '1, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, '1, 1'b0);
    // 2 MiB page at the third level
    push_word(ptw_pkg::ACT_REQUEST, 48'h1234_5678_9ABC, 52'hA_BCDE_F012_3456, '0, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'h8000_0000_0020_0003, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_F001, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'h000F_FFFF_FFE0_0081, 1'b0);
    // fault on the top entry
    push_word(ptw_pkg::ACT_REQUEST, 48'h8000_0000_0000, 52'h0_0000_0000_000F, '0, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    // fault on the second entry, large bit set but not present
    push_word(ptw_pkg::ACT_REQUEST, 48'h7FFF_FFFF_FFFF, 52'h8_0000_0000_0000, '0, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'h3, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'h80, 1'b0);
    // request while busy abandons the running walk
    push_word(ptw_pkg::ACT_REQUEST, 48'h0000_4020_1FFF, 52'h1_0000_0000_1000, '0, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'h0000_0000_0000_2003, 1'b0);
    push_word(ptw_pkg::ACT_REQUEST, 48'hFFFF_C000_0000, 52'h2_0000_0000_2000, '0, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'h7, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'h7, 1'b0);
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'h7, 1'b0);
    // large bit on the leaf is not a page size, still a 4 KiB frame
    push_word(ptw_pkg::ACT_ENTRY, '0, '0, 64'hFFF0_0000_1234_5081, 1'b0);

    // random part: mostly complete walks with random content, some noise
    next_reroll = 0;
    while (words_queued < 1450) begin
      if (words_queued >= next_reroll) begin
        calm_stretch = ($urandom_range(0, 2) == 0);
        next_reroll += 100;
      end
      r = $urandom_range(0, 99);
      if (r < 80) queue_walk(1'b0);
      else if (r < 90) queue_walk(1'b1);
      else if (r < 96) push_word(ptw_pkg::ACT_ENTRY, rand_va(), rand_base(), rand64(), 1'b0);
      else push_word(ptw_pkg::ACT_REQUEST, rand_va(), rand_base(), rand64(), 1'b0);
    end

    // synchronous reset: rst_n starts low and is released here
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    // let anything still in flight show up
    repeat (20) @(negedge clk);

    $display("run covered %0d input words: %0d entry reads, %0d mapped walks, %0d faults",
             words_queued, reads_seen, found_seen, faults_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
